[rtl/sbalu_pkg.sv]
// Shared types and constants for the sixteen-bit ALU with condition flags.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbalu_pkg;

    localparam int unsigned DataWidth = 16;
    localparam int unsigned OpWidth   = 4;

    // Number of quotient bits produced by the iterative divider, one per cycle.
    localparam int unsigned DivSteps  = DataWidth;
    localparam int unsigned CntWidth  = $clog2(DivSteps);

    localparam logic [OpWidth-1:0] OP_ADD  = 4'd0;
    localparam logic [OpWidth-1:0] OP_SUB  = 4'd1;
    localparam logic [OpWidth-1:0] OP_MUL  = 4'd2;
    localparam logic [OpWidth-1:0] OP_DIV  = 4'd3;
    localparam logic [OpWidth-1:0] OP_CMP  = 4'd4;
    localparam logic [OpWidth-1:0] OP_NOT  = 4'd5;
    localparam logic [OpWidth-1:0] OP_AND  = 4'd6;
    localparam logic [OpWidth-1:0] OP_OR   = 4'd7;
    localparam logic [OpWidth-1:0] OP_XOR  = 4'd8;
    localparam logic [OpWidth-1:0] OP_TEST = 4'd9;
    localparam logic [OpWidth-1:0] OP_SHL  = 4'd10;
    localparam logic [OpWidth-1:0] OP_SHR  = 4'd11;

    typedef logic [DataWidth-1:0] word_t;

    typedef struct packed {
        logic zero;
        logic negative;
        logic overflow;
        logic carry;
    } flags_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new beat and set up the divider
        logic step;     // one restoring-division iteration
        logic finish;   // write the result registers and the flags
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic long_op;  // captured beat is a division by a nonzero divisor
    } dp_status_t;

endpackage : sbalu_pkg

`default_nettype wire

[rtl/sbalu_ctrl.sv]
// Controller state machine for the sixteen-bit ALU.
// Sequences load, divider iterations and result write; uses sbalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbalu_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire sbalu_pkg::dp_status_t  status,
    output sbalu_pkg::ctrl_cmd_t        cmd,
    output logic                        busy,
    output logic                        done
);
    import sbalu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CntWidth-1:0]   cnt_reg;
    logic [CntWidth-1:0]   cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.load   = start && !busy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.long_op)
                begin
                    state_next = ST_DIVIDE;
                    cnt_next   = '0;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntWidth'(DivSteps - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
        done_next = cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule : sbalu_ctrl

`default_nettype wire

[rtl/sbalu_dp.sv]
// Datapath for the sixteen-bit ALU: operand registers, combinational operations,
// a restoring divider, condition flags and result registers; uses sbalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbalu_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sbalu_pkg::ctrl_cmd_t        cmd,
    output sbalu_pkg::dp_status_t            status,
    input  wire logic [sbalu_pkg::OpWidth-1:0]   opcode,
    input  wire logic [sbalu_pkg::DataWidth-1:0] dst_value,
    input  wire logic [sbalu_pkg::DataWidth-1:0] src_value,
    output logic [sbalu_pkg::DataWidth-1:0]      result,
    output logic                             writes_result,
    output logic                             flag_zero,
    output logic                             flag_negative,
    output logic                             flag_overflow,
    output logic                             flag_carry,
    output logic                             divide_by_zero
);
    import sbalu_pkg::*;

    localparam int unsigned ShWidth = $clog2(DataWidth + 1);

    logic [OpWidth-1:0]  op_reg;
    word_t               d_reg;
    word_t               s_reg;
    logic                qneg_reg;
    word_t               quo_reg;
    word_t               quo_next;
    word_t               rem_reg;
    word_t               rem_next;
    word_t               dvs_reg;
    flags_t              flags_reg;
    flags_t              flags_next;
    word_t               result_reg;
    word_t               result_next;
    logic                wr_reg;
    logic                wr_next;
    logic                dz_reg;
    logic                dz_next;

    logic [DataWidth:0]   trial;
    logic [DataWidth-1:0] diff;
    logic [ShWidth-1:0]   sh_cnt;
    logic [DataWidth:0]   shl_ext;
    logic [DataWidth:0]   shr_ext;
    logic                 d_sign;
    logic                 s_sign;
    logic                 r_sign;
    word_t                tst;

    assign status.long_op = (op_reg == OP_DIV) && (s_reg != '0);

    // One restoring step: shift the next dividend bit into the partial remainder.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DataWidth-1]} - {1'b0, dvs_reg};
        rem_next = trial[DataWidth] ? {rem_reg[DataWidth-2:0], quo_reg[DataWidth-1]}
                                    : trial[DataWidth-1:0];
        quo_next = {quo_reg[DataWidth-2:0], ~trial[DataWidth]};
    end

    always_comb
    begin
        diff    = d_reg - s_reg;
        sh_cnt  = (s_reg > word_t'(DataWidth)) ? ShWidth'(DataWidth) : s_reg[ShWidth-1:0];
        // The bit just past the kept word is the last one shifted out.
        shl_ext = {1'b0, d_reg} << sh_cnt;
        shr_ext = $signed({d_reg, 1'b0}) >>> sh_cnt;
        d_sign  = d_reg[DataWidth-1];
        s_sign  = s_reg[DataWidth-1];
        r_sign  = diff[DataWidth-1];
        tst     = d_reg & s_reg;

        result_next = d_reg;
        wr_next     = 1'b0;
        dz_next     = 1'b0;
        flags_next  = flags_reg;
        case (op_reg)
            OP_ADD:
            begin
                result_next = d_reg + s_reg;
                wr_next     = 1'b1;
            end
            OP_SUB:
            begin
                result_next = diff;
                wr_next     = 1'b1;
            end
            OP_MUL:
            begin
                result_next = d_reg * s_reg;
                wr_next     = 1'b1;
            end
            OP_DIV:
            begin
                wr_next = 1'b1;
                if (s_reg == '0)
                begin
                    result_next = '1;
                    dz_next     = 1'b1;
                end
                else
                begin
                    result_next = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
                end
            end
            OP_CMP:
            begin
                flags_next.zero     = (diff == '0);
                flags_next.negative = r_sign;
                flags_next.overflow = (!d_sign && s_sign && r_sign)
                                   || (d_sign && !s_sign && !r_sign);
                flags_next.carry    = (!d_sign && s_sign && !r_sign)
                                   || (d_sign && s_sign && r_sign)
                                   || (d_sign && !s_sign && r_sign);
            end
            OP_NOT:
            begin
                result_next = ~s_reg;
                wr_next     = 1'b1;
            end
            OP_AND:
            begin
                result_next = tst;
                wr_next     = 1'b1;
            end
            OP_OR:
            begin
                result_next = d_reg | s_reg;
                wr_next     = 1'b1;
            end
            OP_XOR:
            begin
                result_next = d_reg ^ s_reg;
                wr_next     = 1'b1;
            end
            OP_TEST:
            begin
                flags_next.zero     = (tst == '0);
                flags_next.negative = tst[DataWidth-1];
            end
            OP_SHL:
            begin
                result_next         = shl_ext[DataWidth-1:0];
                wr_next             = 1'b1;
                flags_next.zero     = (shl_ext[DataWidth-1:0] == '0);
                flags_next.negative = shl_ext[DataWidth-1];
                flags_next.carry    = shl_ext[DataWidth];
            end
            OP_SHR:
            begin
                result_next         = shr_ext[DataWidth:1];
                wr_next             = 1'b1;
                flags_next.zero     = (shr_ext[DataWidth:1] == '0);
                flags_next.negative = shr_ext[DataWidth];
                flags_next.carry    = shr_ext[0];
            end
            default:
            begin
                result_next = d_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (cmd.finish)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            d_reg    <= dst_value;
            s_reg    <= src_value;
            qneg_reg <= dst_value[DataWidth-1] ^ src_value[DataWidth-1];
            quo_reg  <= dst_value[DataWidth-1] ? (~dst_value + 1'b1) : dst_value;
            dvs_reg  <= src_value[DataWidth-1] ? (~src_value + 1'b1) : src_value;
            rem_reg  <= '0;
        end
        else if (cmd.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
            wr_reg     <= wr_next;
            dz_reg     <= dz_next;
        end
    end

    assign result         = result_reg;
    assign writes_result  = wr_reg;
    assign divide_by_zero = dz_reg;
    assign flag_zero      = flags_reg.zero;
    assign flag_negative  = flags_reg.negative;
    assign flag_overflow  = flags_reg.overflow;
    assign flag_carry     = flags_reg.carry;

endmodule : sbalu_dp

`default_nettype wire

[rtl/sixteen_bit_alu_with_flags_unit.sv]
// Sixteen-bit ALU with Z, N, O and C condition flags.
// A beat is taken when start is high and busy is low; done marks the result for one cycle.
// done is registered from the finish command; a division by a nonzero divisor first runs its
// sixteen restoring iterations, one quotient bit a cycle, before the result is written.
// One beat at a time; a new beat may start in the cycle done is high. The receiver cannot stall.
// Asynchronous active-low reset idles the controller and clears all four flags.
`timescale 1ns / 1ps
`default_nettype none

module sixteen_bit_alu_with_flags_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [sbalu_pkg::OpWidth-1:0]   opcode,
    input  wire logic [sbalu_pkg::DataWidth-1:0] dst_value,
    input  wire logic [sbalu_pkg::DataWidth-1:0] src_value,
    output logic                                 done,
    output logic [sbalu_pkg::DataWidth-1:0]      result,
    output logic                                 writes_result,
    output logic                                 flag_zero,
    output logic                                 flag_negative,
    output logic                                 flag_overflow,
    output logic                                 flag_carry,
    output logic                                 divide_by_zero
);
    import sbalu_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sbalu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sbalu_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (opcode),
        .dst_value      (dst_value),
        .src_value      (src_value),
        .result         (result),
        .writes_result  (writes_result),
        .flag_zero      (flag_zero),
        .flag_negative  (flag_negative),
        .flag_overflow  (flag_overflow),
        .flag_carry     (flag_carry),
        .divide_by_zero (divide_by_zero)
    );

endmodule : sixteen_bit_alu_with_flags_unit

`default_nettype wire
